/* design/swrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrs_pkg: shared types and constants for the weighted random selector
// Entry store geometry, twister constants and the front/back request format.
// ----------------------------------------------------------------------------
package swrs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int WW = 15;
    localparam int TW = WW + CW;

    localparam logic [63:0] MT_MULT   = 64'd6364136223846793005;
    localparam logic [63:0] MT_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] MT_UPPER  = 64'hFFFFFFFF80000000;
    localparam logic [63:0] MT_LOWER  = 64'h000000007FFFFFFF;
    localparam logic [8:0]  MT_N      = 9'd312;
    localparam logic [8:0]  MT_M      = 9'd156;

    // one closed list handed from the loader to the selector
    typedef struct packed {
        logic [63:0]   seed;
        logic [TW-1:0] total;
        logic [CW-1:0] count;
        logic          truncated;
    } list_req_t;

endpackage
`default_nettype wire

/* design/swrs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrs_front: list loader
// Clamps weights, writes entries into the store, sums the total and latches
// the seed; on the last entry it hands one list request to the back end.
// ----------------------------------------------------------------------------
module swrs_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                entry_index,
    input  wire logic [15:0]               entry_weight,
    input  wire logic [63:0]               seed,
    input  wire logic                      last,
    input  wire logic                      sel_busy,
    output logic                           wr_en,
    output logic [swrs_pkg::AW-1:0]        wr_addr,
    output logic [7+swrs_pkg::WW:0]        wr_data,
    output logic                           req_valid,
    input  wire logic                      req_ready,
    output swrs_pkg::list_req_t            req
);

    logic [swrs_pkg::CW-1:0] count_reg, count_next;
    logic [swrs_pkg::TW-1:0] total_reg, total_next;
    logic [63:0]             seed_reg, seed_next;
    logic                    ovf_reg, ovf_next;
    logic                    pend_reg, pend_next;
    swrs_pkg::list_req_t     req_reg, req_next;
    logic [swrs_pkg::WW-1:0] wpos;
    logic                    fire, room;
    logic [63:0]             seed_use;

    // the store is shared: load only while no list waits and the selector
    // is not busy with the previous one
    assign in_ready = !pend_reg && !sel_busy;
    assign fire     = in_valid && in_ready;
    assign wpos     = entry_weight[15] ? '0 : entry_weight[14:0];
    assign room     = count_reg < swrs_pkg::CW'(swrs_pkg::MAX_ENTRIES);
    assign seed_use = (count_reg == '0 && !ovf_reg) ? seed : seed_reg;

    assign wr_en   = fire && room;
    assign wr_addr = count_reg[swrs_pkg::AW-1:0];
    assign wr_data = {wpos, entry_index};
    assign req_valid = pend_reg;
    assign req       = req_reg;

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        seed_next  = seed_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        req_next   = req_reg;
        if (pend_reg && req_ready)
        begin
            pend_next = 1'b0;
        end
        if (fire)
        begin
            seed_next = seed_use;
            if (room)
            begin
                count_next = count_reg + 1'b1;
                total_next = total_reg + swrs_pkg::TW'(wpos);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (last)
            begin
                req_next.seed      = seed_use;
                req_next.total     = total_next;
                req_next.count     = count_next;
                req_next.truncated = ovf_next;
                pend_next  = 1'b1;
                count_next = '0;
                total_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            seed_reg  <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
            seed_reg  <= seed_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= swrs_pkg::CW'(swrs_pkg::MAX_ENTRIES))
        else $error("entry count beyond store depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg || sel_busy) |-> !wr_en)
        else $error("store written while a list waits");
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> pend_reg && count_reg == '0 && !ovf_reg)
        else $error("list close did not hand over");

endmodule
`default_nettype wire

/* design/swrs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrs_back: selector
// Runs the twister seeding recurrence through S_SEED and S_MUL, tempers the
// first output, scales it by the total and walks the stored entries.
// ----------------------------------------------------------------------------
module swrs_back
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire swrs_pkg::list_req_t       req,
    output logic                           busy,
    output logic [swrs_pkg::AW-1:0]        rd_addr,
    input  wire logic [7+swrs_pkg::WW:0]   rd_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [15:0]                    out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_MUL, S_TEMPER, S_SCALE_A, S_SCALE_B, S_RD,
        S_WALK, S_DONE
    } state_t;

    state_t                  state_reg;
    swrs_pkg::list_req_t     job_reg;
    logic [63:0]             w_reg, w0_reg, w1_reg, w2_reg, prod_reg;
    logic [8:0]              step_reg;
    logic [63:0]             y_reg;
    logic [63:0]             hi_reg, lo_reg;
    logic [swrs_pkg::TW-1:0] pick_reg, cum_reg;
    logic [swrs_pkg::CW-1:0] idx_reg;
    logic [7:0]              chosen_reg;
    logic                    zero_reg, ovalid_reg;
    logic [63:0]             x, y0, y1, y2, y3, t_mix;
    logic [swrs_pkg::TW-1:0] cum_new;
    logic [63:0]             sum_hl;

    assign req_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign busy      = (state_reg != S_IDLE);
    assign rd_addr   = idx_reg[swrs_pkg::AW-1:0];
    assign out_valid = ovalid_reg;
    assign out_data  = {6'd0, job_reg.truncated, zero_reg, chosen_reg};

    always_comb
    begin
        t_mix = w_reg ^ (w_reg >> 62);
        x  = (w0_reg & swrs_pkg::MT_UPPER) | (w1_reg & swrs_pkg::MT_LOWER);
        y0 = w2_reg ^ (x >> 1) ^ (x[0] ? swrs_pkg::MT_MATRIX : 64'd0);
        y1 = y0 ^ ((y0 >> 29) & 64'h5555555555555555);
        y2 = y1 ^ ((y1 << 17) & 64'h71D67FFFEDA60000);
        y3 = y2 ^ ((y2 << 37) & 64'hFFF7EEE000000000);
        cum_new = cum_reg + swrs_pkg::TW'(rd_data[7+swrs_pkg::WW:8]);
        sum_hl  = hi_reg + (lo_reg >> 32);
    end

    // seeding: w_next = MULT*t + i mod 2^64 from three 32x32 partial products
    // (low*low, and the two cross terms of which only the low half counts)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        job_reg <= req;
                        w_reg   <= req.seed;
                        w0_reg  <= req.seed;
                        step_reg <= 9'd1;
                        cum_reg <= '0;
                        idx_reg <= '0;
                        if (req.total == '0)
                        begin
                            zero_reg <= 1'b1;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            zero_reg <= 1'b0;
                            state_reg <= S_SEED;
                        end
                    end
                end
                S_SEED:
                begin
                    prod_reg <= t_mix[31:0] * swrs_pkg::MT_MULT[31:0];
                    hi_reg   <= t_mix[31:0] * swrs_pkg::MT_MULT[63:32] +
                                t_mix[63:32] * swrs_pkg::MT_MULT[31:0];
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    w_reg <= prod_reg + {hi_reg[31:0], 32'd0} + 64'(step_reg);
                    if (step_reg == 9'd1)
                    begin
                        w1_reg <= prod_reg + {hi_reg[31:0], 32'd0} + 64'(step_reg);
                    end
                    if (step_reg == swrs_pkg::MT_M)
                    begin
                        w2_reg <= prod_reg + {hi_reg[31:0], 32'd0} + 64'(step_reg);
                        state_reg <= S_TEMPER;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_SEED;
                    end
                end
                S_TEMPER:
                begin
                    y_reg     <= y3 ^ (y3 >> 43);
                    state_reg <= S_SCALE_A;
                end
                S_SCALE_A:
                begin
                    hi_reg <= y_reg[63:32] * job_reg.total;
                    lo_reg <= y_reg[31:0] * job_reg.total;
                    state_reg <= S_SCALE_B;
                end
                S_SCALE_B:
                begin
                    pick_reg  <= sum_hl[32 +: swrs_pkg::TW];
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    chosen_reg <= rd_data[7:0];
                    cum_reg    <= cum_new;
                    if (zero_reg || pick_reg <= cum_new ||
                        idx_reg + 1'b1 == job_reg.count)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |=> state_reg == S_RD || state_reg == S_DONE)
        else $error("walk left to a wrong state");
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ready |=> ovalid_reg && $stable(out_data))
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> idx_reg < job_reg.count)
        else $error("walk past stored entries");

endmodule
`default_nettype wire

/* design/seeded_weighted_random_select.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeded_weighted_random_select: roulette wheel pick seeded per list
// Loader front end, entry store and twister based selector back end.
// ----------------------------------------------------------------------------
// Entries load one per cycle while no list waits and the selector is idle.
// After the last entry the list is handed over, seeding runs 156 steps, the
// first output is tempered and scaled, entries are walked until the pick is
// reached and the result is registered; a zero total skips seed and scale.
// The next list loads only once the selector is idle again.
// Reset is asynchronous: control clears, the entry store is not cleared.
module seeded_weighted_random_select
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,   // entry_index, entry_weight, seed
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // chosen_index, all_zero, truncated
);

    logic                          wr_en, req_valid, req_ready, sel_busy;
    logic [swrs_pkg::AW-1:0]       wr_addr, rd_addr;
    logic [7+swrs_pkg::WW:0]       wr_data, rd_data_reg;
    logic [7+swrs_pkg::WW:0]       store [swrs_pkg::MAX_ENTRIES];
    swrs_pkg::list_req_t           req;

    swrs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .entry_index  (s_axis_tdata[7:0]),
        .entry_weight (s_axis_tdata[23:8]),
        .seed         (s_axis_tdata[87:24]),
        .last         (s_axis_tlast),
        .sel_busy     (sel_busy),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    swrs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .busy      (sel_busy),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

/* sim/selection_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selection_checker: result predictor and comparator for the selector
// Watches both stream channels, models the list loader and the twister based
// roulette pick, and compares each result request with the oldest expected.
// ----------------------------------------------------------------------------
module selection_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    output int               fail_count,
    output int               pending_picks
);

    typedef struct packed {
        logic [7:0] chosen_index;
        logic       all_zero;
        logic       truncated;
    } pick_t;

    logic [7:0]  list_index [swrs_pkg::MAX_ENTRIES];
    logic [14:0] list_weight [swrs_pkg::MAX_ENTRIES];
    int          list_len;
    logic [63:0] list_seed;
    logic [31:0] list_total;
    logic        list_dropped;
    pick_t       expected_picks [$];

    // first tempered twister output for a seed
    function automatic logic [63:0] first_draw(input logic [63:0] s);
        logic [63:0] w, w0, w1, wm, x, y;
        w  = s;
        w0 = s;
        w1 = '0;
        wm = '0;
        for (int i = 1; i < int'(swrs_pkg::MT_N); i++)
        begin
            w = swrs_pkg::MT_MULT * (w ^ (w >> 62)) + 64'(i);
            if (i == 1) w1 = w;
            if (i == int'(swrs_pkg::MT_M)) wm = w;
        end
        x = (w0 & swrs_pkg::MT_UPPER) | (w1 & swrs_pkg::MT_LOWER);
        y = wm ^ (x >> 1) ^ (x[0] ? swrs_pkg::MT_MATRIX : 64'd0);
        y ^= (y >> 29) & 64'h5555555555555555;
        y ^= (y << 17) & 64'h71D67FFFEDA60000;
        y ^= (y << 37) & 64'hFFF7EEE000000000;
        y ^= y >> 43;
        return y;
    endfunction

    function automatic pick_t roulette_pick();
        pick_t       p;
        logic [127:0] prod;
        logic [63:0] pick, cum;
        p.truncated = list_dropped;
        p.all_zero = 1'b0;
        if (list_total == 0)
        begin
            p.chosen_index = list_index[0];
            p.all_zero = 1'b1;
        end
        else
        begin
            prod = 128'(first_draw(list_seed)) * 128'(list_total);
            pick = prod[127:64];
            p.chosen_index = list_index[list_len-1];
            cum = '0;
            for (int i = 0; i < list_len; i++)
            begin
                cum += 64'(list_weight[i]);
                if (pick <= cum)
                begin
                    p.chosen_index = list_index[i];
                    break;
                end
            end
        end
        return p;
    endfunction

    assign pending_picks = expected_picks.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0]  idx;
        logic [15:0] wt;
        logic [14:0] wpos;
        pick_t       got, want;
        if (!rst_n)
        begin
            list_len = 0;
            list_total = 0;
            list_dropped = 1'b0;
            list_seed = '0;
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                idx = s_axis_tdata[7:0];
                wt = s_axis_tdata[23:8];
                wpos = wt[15] ? 15'd0 : wt[14:0];
                if (list_len == 0 && !list_dropped) list_seed = s_axis_tdata[87:24];
                if (list_len < swrs_pkg::MAX_ENTRIES)
                begin
                    list_index[list_len] = idx;
                    list_weight[list_len] = wpos;
                    list_len++;
                    list_total += wpos;
                end
                else
                    list_dropped = 1'b1;
                if (s_axis_tlast)
                begin
                    expected_picks.push_back(roulette_pick());
                    list_len = 0;
                    list_total = 0;
                    list_dropped = 1'b0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9]};
                if (expected_picks.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result request %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (got !== want || m_axis_tdata[15:10] !== '0)
                    begin
                        if (fail_count < 10)
                            $display({"pick mismatch: exp idx %0d zero %b trunc %b,",
                                      " got idx %0d zero %b trunc %b"},
                                     want.chosen_index, want.all_zero, want.truncated,
                                     got.chosen_index, got.all_zero, got.truncated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the weighted random selector
// Sends entry lists with random gaps and back pressure; the checker predicts.
// ----------------------------------------------------------------------------
module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // entry_index, entry_weight, seed
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // chosen_index, all_zero, truncated
    int          fail_count;
    int          pending_picks;
    int          cycle_count;
    int          entries_sent;
    bit          hold_sink;

    seeded_weighted_random_select u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    selection_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_picks (pending_picks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] rand_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);          // any, negatives too
        if (r == 1) return 16'd0;
        if (r == 2) return 16'h7FFF;
        return 16'($urandom_range(0, 1024));
    endfunction

    // offer one entry and wait for its acceptance
    task automatic send_entry(input logic [7:0] idx, input logic [15:0] wt,
                              input logic [63:0] seed, input logic lst);
        int g;
        g = gap_len();
        repeat (g)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {seed, wt, idx};
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        entries_sent++;
    endtask

    // only the first seed of a list counts; later ones are random noise
    task automatic send_list(input int len, input bit zero_w);
        logic [63:0] seed;
        seed = {$urandom, $urandom};
        for (int i = 0; i < len; i++)
            send_entry(8'($urandom),
                       zero_w ? 16'($urandom_range(0, 1) ? 0 : 16'h8000 | $urandom)
                              : rand_weight(),
                       (i == 0) ? seed : {$urandom, $urandom}, i == len - 1);
    endtask

    task automatic drain_picks();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_picks != 0) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_sink = 1'b0;
            end
            g = gap_len();
            m_axis_tready <= (g == 0);
            @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        hold_sink = 1'b0;
        entries_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lists: extremes, zero totals, negatives, single entries
        send_entry(8'hFF, 16'h7FFF, 64'hFFFFFFFFFFFFFFFF, 1'b1);
        send_entry(8'h00, 16'h0000, 64'h0, 1'b1);
        send_entry(8'h5A, 16'h8000, 64'h0, 1'b1);
        send_entry(8'h11, 16'h0001, 64'd5489, 1'b0);
        send_entry(8'h22, 16'hFFFF, 64'h0, 1'b0);
        send_entry(8'h33, 16'h0100, 64'h0, 1'b1);
        send_entry(8'hAA, 16'h0000, 64'h123456789ABCDEF0, 1'b0);
        send_entry(8'h55, 16'h7FFF, 64'h0, 1'b1);
        send_list(4, 1'b1);
        drain_picks();
        // overflow: store fills, dropped entries, dropped last closes the list
        send_list(swrs_pkg::MAX_ENTRIES + 3, 1'b0);
        send_list(swrs_pkg::MAX_ENTRIES, 1'b0);
        send_list(swrs_pkg::MAX_ENTRIES + 1, 1'b0);
        drain_picks();

        // long receiver hold-off while the sender keeps offering lists
        hold_sink = 1'b1;
        for (int k = 0; k < 8; k++) send_list($urandom_range(1, 6), 1'b0);
        drain_picks();

        while (entries_sent < 780)
        begin
            case ($urandom_range(0, 9))
                0:       send_list($urandom_range(1, 4), 1'b1);
                1:       send_list($urandom_range(20, 70), 1'b0);
                default: send_list($urandom_range(1, 8), 1'b0);
            endcase
        end
        drain_picks();
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending_picks == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
